@@ rtl/core/pwic_pkg.sv @@
// Package for the perpendicular width and image count pipeline.
// Holds the input and result word types, saturation limits and pipeline depths.
// No dependencies.
`default_nettype none

package pwic_pkg;

    // One input word: the three cell edge vectors in signed Q16.16.
    typedef struct packed {
        logic signed [31:0] edge_a_x;
        logic signed [31:0] edge_a_y;
        logic signed [31:0] edge_a_z;
        logic signed [31:0] edge_b_x;
        logic signed [31:0] edge_b_y;
        logic signed [31:0] edge_b_z;
        logic signed [31:0] edge_c_x;
        logic signed [31:0] edge_c_y;
        logic signed [31:0] edge_c_z;
    } t_cell_in;

    // One result word.
    typedef struct packed {
        logic [30:0] width_a;
        logic [30:0] width_b;
        logic [30:0] width_c;
        logic [7:0]  cells_a;
        logic [7:0]  cells_b;
        logic [7:0]  cells_c;
        logic [62:0] box_volume;
        logic        degenerate;
    } t_cell_out;

    // Reset value of the cutoff register: 12.0 in Q16.16.
    localparam logic [30:0] CUTOFF_RESET = 31'd786432;

    // Saturation limits of the result fields.
    localparam logic [30:0] WIDTH_MAX  = 31'h7FFF_FFFF;
    localparam logic [7:0]  COUNT_MAX  = 8'd255;
    localparam logic [62:0] VOLUME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    // Front end: products, cross products, partial products, term sums,
    // final sums and absolute value.
    localparam int FRONT_STAGES = 6;
    // One root bit per stage for the 64-bit length.
    localparam int SQRT_STEPS   = 64;
    // One quotient bit per stage for the 31-bit width.
    localparam int DIV_STEPS    = 31;
    // One quotient bit per stage for the 8-bit cell count.
    localparam int COUNT_STEPS  = 8;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + 1 + DIV_STEPS + 1 + COUNT_STEPS;

endpackage

`default_nettype wire

@@ rtl/core/perpendicular_widths_image_counts.sv @@
// Top level of the perpendicular width and minimum image cell count pipeline.
// Depends on pwic_pkg for the word types, limits and stage counts.
`default_nettype none

// The block accepts one cell word in every clock cycle (busy never rises) and
// returns its results in order, each as a one-cycle strobe on o_valid. The
// pipeline is built from bit serial stages: 64 square root stages for the
// cross product lengths, one saturation stage and 31 divide stages for the
// widths, and one setup stage and 8 divide stages for the cell counts, behind
// six front stages. The results cannot be held off, so the receiver must take
// every strobe. The cutoff register is read by the count setup stage; write
// it only while no word is in flight.
module perpendicular_widths_image_counts (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  pwic_pkg::t_cell_in   i_cell,
    output logic                 o_valid,
    output pwic_pkg::t_cell_out  o_result,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [30:0]          i_cfg_data
);
    import pwic_pkg::*;

    // Handshake and valid chain.
    logic               accept;
    logic [LATENCY-1:0] r_vld;
    logic [30:0]        r_cutoff;

    // Edge vectors as arrays; w_u and w_v select the operands of each cross
    // product: lane 0 is b x c, lane 1 is a x c, lane 2 is a x b.
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic signed [31:0] w_c [3];
    logic signed [31:0] w_u [3][3];
    logic signed [31:0] w_v [3][3];

    // Front stage registers.
    logic signed [63:0]  r_s1_p [3][3];
    logic signed [63:0]  r_s1_q [3][3];
    logic signed [31:0]  r_s1_a [3];
    logic signed [64:0]  r_s2_x [3][3];
    logic signed [31:0]  r_s2_a [3];
    logic signed [64:0]  r_s3_vlo [3];
    logic signed [64:0]  r_s3_vhi [3];
    logic        [63:0]  r_s3_ll [3][3];
    logic signed [65:0]  r_s3_hl [3][3];
    logic signed [65:0]  r_s3_hh [3][3];
    logic signed [96:0]  r_s4_vt [3];
    logic        [127:0] r_s4_sq [3][3];
    logic signed [97:0]  r_s5_vol;
    logic        [127:0] r_s5_sq [3];
    logic        [95:0]  n_vabs;

    // Square root stages.
    logic [127:0] r_sq_rem  [SQRT_STEPS][3];
    logic [63:0]  r_sq_root [SQRT_STEPS+1][3];
    logic [95:0]  r_sq_vol  [SQRT_STEPS+1];
    logic         r_sq_dgn  [SQRT_STEPS+1];

    // Width divide stages.
    logic [95:0] r_dv_rem [DIV_STEPS][3];
    logic [63:0] r_dv_len [DIV_STEPS][3];
    logic [30:0] r_dv_q   [DIV_STEPS+1][3];
    logic        r_dv_fix [DIV_STEPS+1][3];
    logic        r_dv_sat [DIV_STEPS+1][3];
    logic [62:0] r_dv_box [DIV_STEPS+1];
    logic        r_dv_dgn [DIV_STEPS+1];

    // Cell count divide stages.
    logic [38:0] r_ct_rem  [COUNT_STEPS][3];
    logic [30:0] r_ct_w    [COUNT_STEPS+1][3];
    logic [7:0]  r_ct_q    [COUNT_STEPS+1][3];
    logic        r_ct_fen  [COUNT_STEPS+1][3];
    logic [7:0]  r_ct_fval [COUNT_STEPS+1][3];
    logic [62:0] r_ct_box  [COUNT_STEPS+1];
    logic        r_ct_dgn  [COUNT_STEPS+1];

    // The pipeline takes a word in every cycle.
    assign busy        = 1'b0;
    assign accept      = start & ~busy;
    assign o_cfg_ready = 1'b1;

    // Cutoff register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cutoff <= i_cfg_data;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    // Unpack the input word and route cross product operands.
    always_comb begin
        w_a[0] = i_cell.edge_a_x;
        w_a[1] = i_cell.edge_a_y;
        w_a[2] = i_cell.edge_a_z;
        w_b[0] = i_cell.edge_b_x;
        w_b[1] = i_cell.edge_b_y;
        w_b[2] = i_cell.edge_b_z;
        w_c[0] = i_cell.edge_c_x;
        w_c[1] = i_cell.edge_c_y;
        w_c[2] = i_cell.edge_c_z;
        w_u[0] = w_b;
        w_u[1] = w_a;
        w_u[2] = w_a;
        w_v[0] = w_c;
        w_v[1] = w_c;
        w_v[2] = w_b;
    end

    // Stages 1 to 4 per cross product component.
    for (genvar gl = 0; gl < 3; gl++) begin : g_xl
        for (genvar gk = 0; gk < 3; gk++) begin : g_xk
            localparam int K1 = (gk + 1) % 3;
            localparam int K2 = (gk + 2) % 3;
            logic        [31:0] lo;
            logic signed [32:0] hi;

            assign lo = r_s2_x[gl][gk][31:0];
            assign hi = $signed(r_s2_x[gl][gk][64:32]);

            always_ff @(posedge i_clk) begin
                // Stage 1: the two products of the component.
                r_s1_p[gl][gk] <= 64'(w_u[gl][K1]) * 64'(w_v[gl][K2]);
                r_s1_q[gl][gk] <= 64'(w_u[gl][K2]) * 64'(w_v[gl][K1]);
                // Stage 2: exact cross product component.
                r_s2_x[gl][gk] <= 65'(r_s1_p[gl][gk]) - 65'(r_s1_q[gl][gk]);
                // Stage 3: partial products of the square, split at bit 32.
                r_s3_ll[gl][gk] <= 64'(lo) * 64'(lo);
                r_s3_hl[gl][gk] <= 66'(hi) * 66'($signed({1'b0, lo}));
                r_s3_hh[gl][gk] <= 66'(hi) * 66'(hi);
                // Stage 4: the square, which is below 2^127.
                r_s4_sq[gl][gk] <= (128'(r_s3_hh[gl][gk]) << 64)
                                 + (128'(r_s3_hl[gl][gk]) << 33)
                                 + 128'(r_s3_ll[gl][gk]);
            end
        end
    end

    // Stages 1 to 4 of the volume terms a[k] * (b x c)[k].
    for (genvar gk = 0; gk < 3; gk++) begin : g_vol
        logic        [31:0] lo;
        logic signed [32:0] hi;

        assign lo = r_s2_x[0][gk][31:0];
        assign hi = $signed(r_s2_x[0][gk][64:32]);

        always_ff @(posedge i_clk) begin
            r_s1_a[gk]   <= w_a[gk];
            r_s2_a[gk]   <= r_s1_a[gk];
            r_s3_vlo[gk] <= 65'(r_s2_a[gk]) * 65'($signed({1'b0, lo}));
            r_s3_vhi[gk] <= 65'(r_s2_a[gk]) * 65'(hi);
            r_s4_vt[gk]  <= (97'(r_s3_vhi[gk]) <<< 32) + 97'(r_s3_vlo[gk]);
        end
    end

    // Stage 5: volume and squared lengths. Stage 6: absolute volume, which is
    // below 2^96.
    assign n_vabs = r_s5_vol[97] ? 96'(-r_s5_vol) : 96'(r_s5_vol);

    always_ff @(posedge i_clk) begin
        r_s5_vol <= 98'(r_s4_vt[0]) + 98'(r_s4_vt[1]) + 98'(r_s4_vt[2]);
        for (int l = 0; l < 3; l++) begin
            r_s5_sq[l]      <= r_s4_sq[l][0] + r_s4_sq[l][1] + r_s4_sq[l][2];
            r_sq_rem[0][l]  <= r_s5_sq[l];
            r_sq_root[0][l] <= '0;
        end
        r_sq_vol[0] <= n_vabs;
        r_sq_dgn[0] <= (r_s5_vol == '0);
    end

    // Integer square root, one root bit per stage, restoring on the remainder.
    for (genvar gs = 0; gs < SQRT_STEPS; gs++) begin : g_sqrt
        localparam int SB = SQRT_STEPS - 1 - gs;
        for (genvar gl = 0; gl < 3; gl++) begin : g_lane
            logic [127:0] trial;
            logic         take;

            assign trial = (128'(r_sq_root[gs][gl]) << (SB + 1)) + (128'(1) << (2 * SB));
            assign take  = (r_sq_rem[gs][gl] >= trial);

            always_ff @(posedge i_clk) begin
                r_sq_root[gs+1][gl] <= take ? (r_sq_root[gs][gl] | (64'(1) << SB))
                                            : r_sq_root[gs][gl];
            end

            if (gs < SQRT_STEPS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_sq_rem[gs+1][gl] <= take ? (r_sq_rem[gs][gl] - trial)
                                               : r_sq_rem[gs][gl];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_vol[gs+1] <= r_sq_vol[gs];
            r_sq_dgn[gs+1] <= r_sq_dgn[gs];
        end
    end

    // Width setup: saturation check, zero length and box volume.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_dv_rem[0][l] <= r_sq_vol[SQRT_STEPS];
            r_dv_len[0][l] <= r_sq_root[SQRT_STEPS][l];
            r_dv_q[0][l]   <= '0;
            r_dv_sat[0][l] <= (r_sq_vol[SQRT_STEPS] >= (96'(r_sq_root[SQRT_STEPS][l]) << 31));
            r_dv_fix[0][l] <= (r_sq_root[SQRT_STEPS][l] == '0)
                            || (r_sq_vol[SQRT_STEPS] >= (96'(r_sq_root[SQRT_STEPS][l]) << 31));
        end
        r_dv_box[0] <= r_sq_vol[SQRT_STEPS][95] ? VOLUME_MAX : r_sq_vol[SQRT_STEPS][94:32];
        r_dv_dgn[0] <= r_sq_dgn[SQRT_STEPS];
    end

    // Width division, one quotient bit per stage.
    for (genvar gs = 0; gs < DIV_STEPS; gs++) begin : g_div
        localparam int DB = DIV_STEPS - 1 - gs;
        for (genvar gl = 0; gl < 3; gl++) begin : g_lane
            logic [95:0] dsub;
            logic        take;

            assign dsub = 96'(r_dv_len[gs][gl]) << DB;
            assign take = (r_dv_rem[gs][gl] >= dsub);

            always_ff @(posedge i_clk) begin
                r_dv_q[gs+1][gl]   <= take ? (r_dv_q[gs][gl] | (31'(1) << DB)) : r_dv_q[gs][gl];
                r_dv_fix[gs+1][gl] <= r_dv_fix[gs][gl];
                r_dv_sat[gs+1][gl] <= r_dv_sat[gs][gl];
            end

            if (gs < DIV_STEPS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_dv_rem[gs+1][gl] <= take ? (r_dv_rem[gs][gl] - dsub) : r_dv_rem[gs][gl];
                    r_dv_len[gs+1][gl] <= r_dv_len[gs][gl];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_box[gs+1] <= r_dv_box[gs];
            r_dv_dgn[gs+1] <= r_dv_dgn[gs];
        end
    end

    // Count setup: final width, rounding offset and the special cases.
    for (genvar gl = 0; gl < 3; gl++) begin : g_cset
        logic [30:0] width;
        logic [31:0] num;
        logic [32:0] nup;
        logic        over;

        assign width = r_dv_fix[DIV_STEPS][gl]
                     ? (r_dv_sat[DIV_STEPS][gl] ? WIDTH_MAX : 31'd0)
                     : r_dv_q[DIV_STEPS][gl];
        assign num   = {r_cutoff, 1'b0};
        assign nup   = 33'(num) + 33'(width) - 33'd1;
        assign over  = (39'(nup) >= (39'(width) << 8));

        always_ff @(posedge i_clk) begin
            r_ct_w[0][gl]    <= width;
            r_ct_rem[0][gl]  <= 39'(nup);
            r_ct_q[0][gl]    <= '0;
            r_ct_fen[0][gl]  <= (num == '0) || (width == '0) || over;
            r_ct_fval[0][gl] <= (num == '0) ? 8'd0 : COUNT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ct_box[0] <= r_dv_box[DIV_STEPS];
        r_ct_dgn[0] <= r_dv_dgn[DIV_STEPS];
    end

    // Count division, one quotient bit per stage.
    for (genvar gs = 0; gs < COUNT_STEPS; gs++) begin : g_cnt
        localparam int CB = COUNT_STEPS - 1 - gs;
        for (genvar gl = 0; gl < 3; gl++) begin : g_lane
            logic [38:0] dsub;
            logic        take;

            assign dsub = 39'(r_ct_w[gs][gl]) << CB;
            assign take = (r_ct_rem[gs][gl] >= dsub);

            always_ff @(posedge i_clk) begin
                r_ct_q[gs+1][gl]    <= take ? (r_ct_q[gs][gl] | (8'(1) << CB)) : r_ct_q[gs][gl];
                r_ct_w[gs+1][gl]    <= r_ct_w[gs][gl];
                r_ct_fen[gs+1][gl]  <= r_ct_fen[gs][gl];
                r_ct_fval[gs+1][gl] <= r_ct_fval[gs][gl];
            end

            if (gs < COUNT_STEPS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_ct_rem[gs+1][gl] <= take ? (r_ct_rem[gs][gl] - dsub) : r_ct_rem[gs][gl];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_ct_box[gs+1] <= r_ct_box[gs];
            r_ct_dgn[gs+1] <= r_ct_dgn[gs];
        end
    end

    // Result word; a degenerate cell reports zero widths and counts.
    always_comb begin
        logic [30:0] w [3];
        logic [7:0]  n [3];
        for (int l = 0; l < 3; l++) begin
            w[l] = r_ct_dgn[COUNT_STEPS] ? 31'd0 : r_ct_w[COUNT_STEPS][l];
            n[l] = r_ct_dgn[COUNT_STEPS] ? 8'd0
                 : (r_ct_fen[COUNT_STEPS][l] ? r_ct_fval[COUNT_STEPS][l]
                                             : r_ct_q[COUNT_STEPS][l]);
        end
        o_result.width_a    = w[0];
        o_result.width_b    = w[1];
        o_result.width_c    = w[2];
        o_result.cells_a    = n[0];
        o_result.cells_b    = n[1];
        o_result.cells_c    = n[2];
        o_result.box_volume = r_ct_box[COUNT_STEPS];
        o_result.degenerate = r_ct_dgn[COUNT_STEPS];
    end

    assign o_valid = r_vld[LATENCY-1];

endmodule

`default_nettype wire
